// File: hw/rtl/difl_pkg.sv
// shared types, constants and helpers for the descriptor index free list
// depends on nothing; used by the interfaces, difl_queue and the top level
package difl_pkg;

    // free queue geometry
    localparam int POOL_DEPTH = 1024;
    localparam int AW         = $clog2(POOL_DEPTH);
    localparam int CW         = $clog2(POOL_DEPTH + 1);
    localparam int SW         = CW + 1;

    // field widths
    localparam int KIND_W   = 2;
    localparam int IDX_W    = 10;
    localparam int STAT_W   = 3;
    localparam int ADDR_W   = 64;
    localparam int MAXD_W   = 11;
    localparam int STRIDE_W = 13;
    localparam int OFF_W    = IDX_W + STRIDE_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 64;
    localparam int CMP_W    = (CW > IDX_W) ? CW : IDX_W;

    // largest usable pool: bounded by the queue and by the index width
    localparam int IDX_SPAN = 1 << IDX_W;
    localparam int POOL_CAP = (POOL_DEPTH < IDX_SPAN) ? POOL_DEPTH : IDX_SPAN;

    // register reset values
    localparam logic [MAXD_W-1:0]   RST_MAXD   = MAXD_W'(1024);
    localparam logic [STRIDE_W-1:0] RST_STRIDE = STRIDE_W'(32);

    typedef enum logic [KIND_W-1:0] {
        K_ALLOC  = 2'd0,
        K_FREE   = 2'd1,
        K_LOOKUP = 2'd2,
        K_REINIT = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_RANGE   = 3'd2,
        ST_FULL    = 3'd3,
        ST_INVALID = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        R_MAXD   = 2'd0,
        R_STRIDE = 2'd1,
        R_CPU    = 2'd2,
        R_GPU    = 2'd3
    } t_cfg_reg;

    // queue commands from the sequencer
    typedef struct packed {
        logic             pop;
        logic             push;
        logic [IDX_W-1:0] push_data;
        logic             refill;
        logic [CW-1:0]    refill_n;
    } t_q_cmd;

    // queue status back to the sequencer
    typedef struct packed {
        logic [CW-1:0]    count;
        logic [IDX_W-1:0] pop_index;
    } t_q_stat;

    // effective pool size from the slot-count register
    function automatic logic [CW-1:0] pool_size(input logic [MAXD_W-1:0] m);
        logic [CW-1:0] n;
        if (m > MAXD_W'(POOL_CAP)) begin
            n = CW'(POOL_CAP);
        end else begin
            n = CW'(m);
        end
        return n;
    endfunction

endpackage

// File: hw/rtl/difl_req_if.sv
// request channel: valid/ready handshake carrying one request word
// depends on difl_pkg for field widths
interface difl_req_if;
    logic                             valid;
    logic                             ready;
    logic [difl_pkg::KIND_W-1:0]      kind;
    logic [difl_pkg::IDX_W-1:0]       slot_index;
    logic                             handle_valid;

    modport source (output valid, kind, slot_index, handle_valid, input ready);
    modport sink   (input valid, kind, slot_index, handle_valid, output ready);
endinterface

// File: hw/rtl/difl_rsp_if.sv
// response channel: valid/ready handshake carrying one result word
// depends on difl_pkg for field widths
interface difl_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [difl_pkg::STAT_W-1:0]      status;
    logic [difl_pkg::IDX_W-1:0]       result_index;
    logic [difl_pkg::ADDR_W-1:0]      cpu_address;
    logic [difl_pkg::ADDR_W-1:0]      gpu_address;

    modport source (output valid, status, result_index, cpu_address, gpu_address,
                    input ready);
    modport sink   (input valid, status, result_index, cpu_address, gpu_address,
                    output ready);
endinterface

// File: hw/rtl/difl_queue.sv
// circular free queue of slot indices held in one synchronous memory
// depends on difl_pkg; refill is instant through a window of untouched entries
module difl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  difl_pkg::t_q_cmd i_cmd,
    output difl_pkg::t_q_stat o_stat
);

    localparam int D = difl_pkg::POOL_DEPTH;

    logic [difl_pkg::IDX_W-1:0] r_mem [D];
    logic [difl_pkg::IDX_W-1:0] r_rd;
    logic [difl_pkg::AW-1:0]    r_head;
    logic [difl_pkg::AW-1:0]    r_tail;
    logic [difl_pkg::CW-1:0]    r_count;
    // size at the last refill, and pushes since then (saturating)
    logic [difl_pkg::CW-1:0]    r_fill_n;
    logic [difl_pkg::CW-1:0]    r_pushed;
    logic                       r_prist;
    logic [difl_pkg::AW-1:0]    r_pop_pos;

    logic [difl_pkg::AW-1:0]    head_nx;
    logic [difl_pkg::AW-1:0]    tail_nx;
    logic [difl_pkg::AW-1:0]    refill_tail;
    logic                       head_prist;
    logic [difl_pkg::CW-1:0]    rst_n_pool;

    assign rst_n_pool = difl_pkg::pool_size(difl_pkg::RST_MAXD);

    // pointer increments with wrap
    assign head_nx = (r_head == difl_pkg::AW'(D - 1)) ? '0 : r_head + 1'b1;
    assign tail_nx = (r_tail == difl_pkg::AW'(D - 1)) ? '0 : r_tail + 1'b1;
    assign refill_tail = (i_cmd.refill_n == difl_pkg::CW'(D)) ? '0 :
                         difl_pkg::AW'(i_cmd.refill_n);

    // head still holds its refill value (position equals index) when it lies
    // below the refill size and the tail has not yet wrapped over it
    assign head_prist =
        (difl_pkg::CW'(r_head) < r_fill_n) &&
        ((difl_pkg::SW'(r_head) + difl_pkg::SW'(D)) >=
         (difl_pkg::SW'(r_fill_n) + difl_pkg::SW'(r_pushed)));

    // memory: one write port at the tail, registered read at the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= i_cmd.push_data;
        end
        r_rd <= r_mem[r_head];
    end

    // pop bookkeeping for the word read this cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_pop_pos <= r_head;
            r_prist   <= head_prist;
        end
    end

    // pointers and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= (rst_n_pool == difl_pkg::CW'(D)) ? '0 : difl_pkg::AW'(rst_n_pool);
            r_count  <= rst_n_pool;
            r_fill_n <= rst_n_pool;
            r_pushed <= '0;
        end else if (i_cmd.refill) begin
            r_head   <= '0;
            r_tail   <= refill_tail;
            r_count  <= i_cmd.refill_n;
            r_fill_n <= i_cmd.refill_n;
            r_pushed <= '0;
        end else if (i_cmd.push) begin
            r_tail   <= tail_nx;
            r_count  <= r_count + 1'b1;
            if (r_pushed != difl_pkg::CW'(D)) begin
                r_pushed <= r_pushed + 1'b1;
            end
        end else if (i_cmd.pop) begin
            r_head  <= head_nx;
            r_count <= r_count - 1'b1;
        end
    end

    assign o_stat.count     = r_count;
    assign o_stat.pop_index = r_prist ? difl_pkg::IDX_W'(r_pop_pos) : r_rd;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= difl_pkg::CW'(D))
        else $error("free queue count above depth");

    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.push && i_cmd.pop) && !(i_cmd.refill && (i_cmd.push || i_cmd.pop)))
        else $error("overlapping queue commands");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push && !i_cmd.refill |=> r_count == $past(r_count) + 1'b1)
        else $error("push did not grow the queue");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> r_count != '0)
        else $error("pop from an empty queue");

endmodule

// File: hw/rtl/descriptor_index_free_list.sv
// descriptor index free list: a request is taken only in idle; its result word is
// registered after the queue read, offset multiply and base add steps, and the next
// request is taken only once that word is loaded, which waits while the response stalls.
// a waiting result does not block the next request, which stalls only at its add.
// reset is synchronous and refills the pool through the queue pointers; no clearing pass.
// depends on difl_pkg, difl_req_if, difl_rsp_if and difl_queue
module descriptor_index_free_list (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    difl_req_if.sink                       i_req,
    difl_rsp_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [difl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [difl_pkg::CFG_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_IDX,
        S_MUL,
        S_OUT
    } t_state;

    t_state                        r_state;
    logic [difl_pkg::MAXD_W-1:0]   r_maxd;
    logic [difl_pkg::STRIDE_W-1:0] r_stride;
    logic [difl_pkg::ADDR_W-1:0]   r_cpu_base;
    logic [difl_pkg::ADDR_W-1:0]   r_gpu_base;

    difl_pkg::t_status             r_stat;
    logic                          r_has_addr;
    logic                          r_from_q;
    logic [difl_pkg::IDX_W-1:0]    r_idx;
    logic [difl_pkg::OFF_W-1:0]    r_off;

    logic                          r_out_valid;
    logic [difl_pkg::STAT_W-1:0]   r_out_stat;
    logic [difl_pkg::IDX_W-1:0]    r_out_idx;
    logic [difl_pkg::ADDR_W-1:0]   r_out_cpu;
    logic [difl_pkg::ADDR_W-1:0]   r_out_gpu;

    difl_pkg::t_q_cmd              q_cmd;
    difl_pkg::t_q_stat             q_stat;
    logic                          accept;
    logic                          out_free;
    logic                          q_full;
    logic [difl_pkg::CW-1:0]       pool_n;
    logic                          lookup_oob;
    difl_pkg::t_status             dec_stat;
    logic                          dec_has_addr;
    logic                          dec_from_q;

    // handshake
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign pool_n     = difl_pkg::pool_size(r_maxd);
    assign q_full     = (q_stat.count == difl_pkg::CW'(difl_pkg::POOL_DEPTH));
    assign lookup_oob = difl_pkg::CMP_W'(i_req.slot_index) >= difl_pkg::CMP_W'(pool_n);

    // queue commands issued on acceptance
    always_comb begin
        q_cmd.pop       = 1'b0;
        q_cmd.push      = 1'b0;
        q_cmd.push_data = i_req.slot_index;
        q_cmd.refill    = 1'b0;
        q_cmd.refill_n  = pool_n;
        if (accept) begin
            unique case (difl_pkg::t_kind'(i_req.kind))
                difl_pkg::K_ALLOC:  q_cmd.pop    = (q_stat.count != '0);
                difl_pkg::K_FREE:   q_cmd.push   = i_req.handle_valid && !q_full;
                difl_pkg::K_LOOKUP: q_cmd.pop    = 1'b0;
                difl_pkg::K_REINIT: q_cmd.refill = 1'b1;
            endcase
        end
    end

    // result class of the accepted word
    always_comb begin
        dec_stat     = difl_pkg::ST_OK;
        dec_has_addr = 1'b0;
        dec_from_q   = 1'b0;
        if (accept) begin
            unique case (difl_pkg::t_kind'(i_req.kind))
                difl_pkg::K_ALLOC: begin
                    if (q_stat.count == '0) begin
                        dec_stat = difl_pkg::ST_EMPTY;
                    end else begin
                        dec_has_addr = 1'b1;
                        dec_from_q   = 1'b1;
                    end
                end
                difl_pkg::K_FREE: begin
                    if (!i_req.handle_valid) begin
                        dec_stat = difl_pkg::ST_INVALID;
                    end else if (q_full) begin
                        dec_stat = difl_pkg::ST_FULL;
                    end
                end
                difl_pkg::K_LOOKUP: begin
                    if (lookup_oob) begin
                        dec_stat = difl_pkg::ST_RANGE;
                    end else begin
                        dec_has_addr = 1'b1;
                    end
                end
                difl_pkg::K_REINIT: begin
                    dec_stat = difl_pkg::ST_OK;
                end
            endcase
        end
    end

    difl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maxd     <= difl_pkg::RST_MAXD;
            r_stride   <= difl_pkg::RST_STRIDE;
            r_cpu_base <= '0;
            r_gpu_base <= '0;
        end else if (i_cfg_we) begin
            unique case (difl_pkg::t_cfg_reg'(i_cfg_idx))
                difl_pkg::R_MAXD:   r_maxd     <= i_cfg_data[difl_pkg::MAXD_W-1:0];
                difl_pkg::R_STRIDE: r_stride   <= i_cfg_data[difl_pkg::STRIDE_W-1:0];
                difl_pkg::R_CPU:    r_cpu_base <= i_cfg_data;
                difl_pkg::R_GPU:    r_gpu_base <= i_cfg_data;
            endcase
        end
    end

    // sequencer and result word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a word taken outside the add step leaves the register empty
            if (r_out_valid && o_rsp.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state    <= S_IDX;
                        r_stat     <= dec_stat;
                        r_has_addr <= dec_has_addr;
                        r_from_q   <= dec_from_q;
                        r_idx      <= i_req.slot_index;
                    end
                end
                S_IDX: begin
                    // popped index arrives from the memory read
                    if (r_from_q) begin
                        r_idx <= q_stat.pop_index;
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_off   <= difl_pkg::OFF_W'(r_idx) * difl_pkg::OFF_W'(r_stride);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // add bases once the result register is free
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_stat  <= r_stat;
                        r_out_idx   <= r_has_addr ? r_idx : '0;
                        r_out_cpu   <= r_has_addr ?
                                       r_cpu_base + difl_pkg::ADDR_W'(r_off) : '0;
                        r_out_gpu   <= r_has_addr ?
                                       r_gpu_base + difl_pkg::ADDR_W'(r_off) : '0;
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_stat;
    assign o_rsp.result_index = r_out_idx;
    assign o_rsp.cpu_address  = r_out_cpu;
    assign o_rsp.gpu_address  = r_out_gpu;

    // checks
    a_accept_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_IDX)
        else $error("accepted word did not start the sequence");

    a_no_addr_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_stat != difl_pkg::ST_OK) |->
        (r_out_idx == '0) && (r_out_cpu == '0) && (r_out_gpu == '0))
        else $error("error result carries an address");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) && !out_free |=> (r_state == S_OUT) && r_out_valid)
        else $error("result register overwritten while occupied");

    a_pop_only_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_cmd.pop |-> accept && (i_req.kind == difl_pkg::K_ALLOC))
        else $error("queue pop outside an allocate");

endmodule

// File: dv/tb_descriptor_index_free_list.sv
// testbench for descriptor_index_free_list: directed and random request words,
// results predicted by an in-bench free queue and compared word by word
// depends on difl_pkg, difl_req_if, difl_rsp_if and the top level
`timescale 1ns / 100ps

module tb_descriptor_index_free_list;

    // one request word as queued for the driver
    typedef struct {
        difl_pkg::t_kind            kind;
        logic [difl_pkg::IDX_W-1:0] slot;
        logic                       hv;
    } t_request;

    // one predicted result word
    typedef struct {
        difl_pkg::t_status           status;
        logic [difl_pkg::IDX_W-1:0]  slot;
        logic [difl_pkg::ADDR_W-1:0] cpu_addr;
        logic [difl_pkg::ADDR_W-1:0] gpu_addr;
    } t_answer;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we;
    logic [difl_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [difl_pkg::CFG_W-1:0]     i_cfg_data;

    difl_req_if req_if ();
    difl_rsp_if rsp_if ();

    descriptor_index_free_list DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow registers
    logic [difl_pkg::MAXD_W-1:0]   slots_reg;
    logic [difl_pkg::STRIDE_W-1:0] stride_reg;
    logic [difl_pkg::ADDR_W-1:0]   cpu_reg;
    logic [difl_pkg::ADDR_W-1:0]   gpu_reg;

    // shadow free queue
    logic [difl_pkg::IDX_W-1:0] fifo_mem [difl_pkg::POOL_DEPTH];
    int                         rd_pos;
    int                         wr_pos;
    int                         fill_cnt;

    t_request                   req_q[$];
    t_answer                    want_q[$];
    logic [difl_pkg::IDX_W-1:0] held_idx[$];

    int errors = 0;
    int taken_cnt = 0;
    int idle_left = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    bit no_gaps = 1'b0;
    bit no_stalls = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // usable slots: register saturated to the queue depth and the index span
    function automatic int live_slots();
        int n;
        n = int'(slots_reg);
        if (n > difl_pkg::POOL_DEPTH) n = difl_pkg::POOL_DEPTH;
        if (n > difl_pkg::IDX_SPAN) n = difl_pkg::IDX_SPAN;
        return n;
    endfunction

    function automatic void refill_pool();
        int n;
        n = live_slots();
        for (int i = 0; i < difl_pkg::POOL_DEPTH; i++) begin
            fifo_mem[i] = (i < n) ? difl_pkg::IDX_W'(i) : '0;
        end
        rd_pos   = 0;
        wr_pos   = (n >= difl_pkg::POOL_DEPTH) ? 0 : n;
        fill_cnt = n;
    endfunction

    function automatic t_answer with_address(input logic [difl_pkg::IDX_W-1:0] slot);
        t_answer a;
        logic [difl_pkg::ADDR_W-1:0] off;
        off = difl_pkg::ADDR_W'(slot) * difl_pkg::ADDR_W'(stride_reg);
        a.status   = difl_pkg::ST_OK;
        a.slot     = slot;
        a.cpu_addr = cpu_reg + off;
        a.gpu_addr = gpu_reg + off;
        return a;
    endfunction

    // next result of the free list for one accepted word, updating the shadow state
    function automatic t_answer free_list_step(input difl_pkg::t_kind k,
                                               input logic [difl_pkg::IDX_W-1:0] slot,
                                               input logic hv);
        t_answer a;
        logic [difl_pkg::IDX_W-1:0] got;
        a = '{difl_pkg::ST_OK, '0, '0, '0};
        case (k)
            difl_pkg::K_ALLOC: begin
                if (fill_cnt == 0) begin
                    a.status = difl_pkg::ST_EMPTY;
                end else begin
                    got = fifo_mem[rd_pos];
                    rd_pos = (rd_pos + 1) % difl_pkg::POOL_DEPTH;
                    fill_cnt--;
                    a = with_address(got);
                    held_idx.push_back(got);
                end
            end
            difl_pkg::K_FREE: begin
                if (!hv) begin
                    a.status = difl_pkg::ST_INVALID;
                end else if (fill_cnt >= difl_pkg::POOL_DEPTH) begin
                    a.status = difl_pkg::ST_FULL;
                end else begin
                    fifo_mem[wr_pos] = slot;
                    wr_pos = (wr_pos + 1) % difl_pkg::POOL_DEPTH;
                    fill_cnt++;
                end
            end
            difl_pkg::K_LOOKUP: begin
                if (int'(slot) >= live_slots()) begin
                    a.status = difl_pkg::ST_RANGE;
                end else begin
                    a = with_address(slot);
                end
            end
            default: begin
                refill_pool();
                held_idx.delete();
            end
        endcase
        return a;
    endfunction

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    // request driver: predicts each word as it is taken
    always @(posedge i_clk) begin
        t_request nxt;
        if (!i_rst_n) begin
            req_if.valid        <= 1'b0;
            req_if.kind         <= difl_pkg::K_ALLOC;
            req_if.slot_index   <= '0;
            req_if.handle_valid <= 1'b0;
            idle_left = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                want_q.push_back(free_list_step(difl_pkg::t_kind'(req_if.kind),
                                                req_if.slot_index,
                                                req_if.handle_valid));
                taken_cnt++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (idle_left == 0 && req_q.size() > 0) begin
                    nxt = req_q.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.kind         <= nxt.kind;
                    req_if.slot_index   <= nxt.slot;
                    req_if.handle_valid <= nxt.hv;
                    idle_left = no_gaps ? 0 : pick_gap();
                end else begin
                    if (idle_left > 0) idle_left--;
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response ready: random stalls plus one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else if (!long_hold_done && taken_cnt >= 60) begin
            long_hold_done = 1'b1;
            hold_left = 90;
            rsp_if.ready <= 1'b0;
        end else if (no_stalls || $urandom_range(99) < 60) begin
            rsp_if.ready <= 1'b1;
        end else begin
            hold_left = pick_gap();
            rsp_if.ready <= 1'b0;
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        t_answer w;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (want_q.size() == 0) begin
                report_mismatch("unexpected word, status", 64'(rsp_if.status), '0);
            end else begin
                w = want_q.pop_front();
                if (rsp_if.status !== w.status)
                    report_mismatch("status", 64'(rsp_if.status), 64'(w.status));
                if (rsp_if.result_index !== w.slot)
                    report_mismatch("result_index", 64'(rsp_if.result_index),
                                    64'(w.slot));
                if (rsp_if.cpu_address !== w.cpu_addr)
                    report_mismatch("cpu_address", rsp_if.cpu_address, w.cpu_addr);
                if (rsp_if.gpu_address !== w.gpu_addr)
                    report_mismatch("gpu_address", rsp_if.gpu_address, w.gpu_addr);
            end
        end
    end

    task automatic send(input difl_pkg::t_kind k, input int slot, input bit hv);
        t_request it;
        it.kind = k;
        it.slot = difl_pkg::IDX_W'(slot);
        it.hv   = hv;
        while (req_q.size() >= 4) @(posedge i_clk);
        req_q.push_back(it);
    endtask

    // wait until every queued word is taken and every result has come back
    task automatic settle();
        int waited;
        waited = 0;
        while ((req_q.size() != 0 || req_if.valid || want_q.size() != 0) &&
               waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (want_q.size() != 0) begin
            report_mismatch("results still outstanding", 64'(want_q.size()), '0);
            want_q.delete();
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input difl_pkg::t_cfg_reg r,
                             input logic [difl_pkg::CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (r)
            difl_pkg::R_MAXD:   slots_reg  = v[difl_pkg::MAXD_W-1:0];
            difl_pkg::R_STRIDE: stride_reg = v[difl_pkg::STRIDE_W-1:0];
            difl_pkg::R_CPU:    cpu_reg    = v;
            difl_pkg::R_GPU:    gpu_reg    = v;
            default:  ;
        endcase
    endtask

    // random words; frees mostly hand back slots that were allocated earlier
    task automatic gen_phase(input int count, input int w_alloc, input int w_free);
        int k;
        int roll;
        int pick;
        int n;
        int slot;
        for (k = 0; k < count; k++) begin
            n = live_slots();
            roll = $urandom_range(99);
            if (roll < 2) begin
                send(difl_pkg::K_REINIT, $urandom_range(1023), 1'($urandom_range(1)));
            end else if (roll < 2 + w_alloc) begin
                send(difl_pkg::K_ALLOC, $urandom_range(1023), 1'($urandom_range(1)));
            end else if (roll < 2 + w_alloc + w_free) begin
                if (held_idx.size() > 0 && $urandom_range(4) != 0) begin
                    pick = $urandom_range(held_idx.size() - 1);
                    slot = int'(held_idx[pick]);
                    held_idx.delete(pick);
                end else begin
                    slot = $urandom_range(1023);
                end
                send(difl_pkg::K_FREE, slot, $urandom_range(9) != 0);
            end else begin
                if (n > 0 && $urandom_range(3) != 0) slot = $urandom_range(n - 1);
                else slot = $urandom_range(1023);
                send(difl_pkg::K_LOOKUP, slot, 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        i_cfg_we            = 1'b0;
        i_cfg_idx           = difl_pkg::R_MAXD;
        i_cfg_data          = '0;

        slots_reg  = difl_pkg::RST_MAXD;
        stride_reg = difl_pkg::RST_STRIDE;
        cpu_reg    = '0;
        gpu_reg    = '0;
        refill_pool();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset pool: full queue, both range ends, invalid and dropped frees
        send(difl_pkg::K_LOOKUP, 0, 1'b0);
        send(difl_pkg::K_LOOKUP, 1023, 1'b1);
        send(difl_pkg::K_FREE, 7, 1'b1);
        send(difl_pkg::K_FREE, 1023, 1'b0);
        send(difl_pkg::K_ALLOC, 0, 1'b0);
        send(difl_pkg::K_ALLOC, 1023, 1'b1);
        send(difl_pkg::K_FREE, 1023, 1'b1);
        send(difl_pkg::K_FREE, 0, 1'b1);
        send(difl_pkg::K_FREE, 5, 1'b1);
        settle();

        // size change without reinitialise, wrapping addresses, then an empty pool
        write_reg(difl_pkg::R_CPU, '1);
        write_reg(difl_pkg::R_GPU, 64'h8000_0000_0000_0000);
        write_reg(difl_pkg::R_STRIDE, 64'd8191);
        write_reg(difl_pkg::R_MAXD, 64'd0);
        send(difl_pkg::K_LOOKUP, 0, 1'b1);
        send(difl_pkg::K_ALLOC, 0, 1'b0);
        send(difl_pkg::K_REINIT, 0, 1'b0);
        send(difl_pkg::K_ALLOC, 1023, 1'b1);
        send(difl_pkg::K_FREE, 1023, 1'b1);
        send(difl_pkg::K_ALLOC, 0, 1'b0);
        send(difl_pkg::K_ALLOC, 0, 1'b0);
        send(difl_pkg::K_FREE, 0, 1'b0);
        settle();

        // single slot with zero stride
        write_reg(difl_pkg::R_MAXD, 64'd1);
        write_reg(difl_pkg::R_STRIDE, 64'd0);
        write_reg(difl_pkg::R_CPU, {$urandom, $urandom});
        write_reg(difl_pkg::R_GPU, {$urandom, $urandom});
        send(difl_pkg::K_REINIT, 0, 1'b0);
        send(difl_pkg::K_LOOKUP, 0, 1'b0);
        send(difl_pkg::K_LOOKUP, 1, 1'b0);
        send(difl_pkg::K_ALLOC, 0, 1'b0);
        send(difl_pkg::K_ALLOC, 0, 1'b0);
        send(difl_pkg::K_FREE, 0, 1'b1);
        send(difl_pkg::K_REINIT, 1023, 1'b1);
        settle();

        // full pool, random stride and bases; the long hold-off lands here
        write_reg(difl_pkg::R_MAXD, 64'd1024);
        write_reg(difl_pkg::R_STRIDE, 64'($urandom_range(4096, 1)));
        write_reg(difl_pkg::R_CPU, {$urandom, $urandom});
        write_reg(difl_pkg::R_GPU, {$urandom, $urandom});
        send(difl_pkg::K_REINIT, 0, 1'b0);
        gen_phase(120, 45, 35);
        settle();

        // tiny pool: runs dry and refills often
        write_reg(difl_pkg::R_MAXD, 64'd4);
        write_reg(difl_pkg::R_STRIDE, 64'd4096);
        send(difl_pkg::K_REINIT, 0, 1'b0);
        gen_phase(100, 45, 40);
        settle();

        // near-full pool so the write pointer wraps; no idling on either side
        no_gaps   = 1'b1;
        no_stalls = 1'b1;
        write_reg(difl_pkg::R_MAXD, 64'd1000);
        write_reg(difl_pkg::R_STRIDE, 64'd1);
        write_reg(difl_pkg::R_CPU, 64'd0);
        write_reg(difl_pkg::R_GPU, '1);
        send(difl_pkg::K_REINIT, 0, 1'b0);
        gen_phase(100, 25, 55);
        settle();
        no_gaps   = 1'b0;
        no_stalls = 1'b0;

        // oversized slot count saturates; largest stride and bases
        write_reg(difl_pkg::R_MAXD, 64'd2047);
        write_reg(difl_pkg::R_STRIDE, 64'd8191);
        write_reg(difl_pkg::R_CPU, '1);
        write_reg(difl_pkg::R_GPU, '1);
        send(difl_pkg::K_REINIT, 0, 1'b0);
        gen_phase(80, 40, 40);
        settle();

        // random size taken over without reinitialise first
        write_reg(difl_pkg::R_MAXD, 64'($urandom_range(1024, 1)));
        write_reg(difl_pkg::R_STRIDE, 64'($urandom_range(8191)));
        write_reg(difl_pkg::R_CPU, {$urandom, $urandom});
        write_reg(difl_pkg::R_GPU, {$urandom, $urandom});
        gen_phase(150, 40, 38);
        settle();

        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/difl_pkg.sv
hw/rtl/difl_req_if.sv
hw/rtl/difl_rsp_if.sv
hw/rtl/difl_queue.sv
hw/rtl/descriptor_index_free_list.sv
dv/tb_descriptor_index_free_list.sv
